[rtl/mcet_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mcet_pkg;

  localparam int DATA_W  = 64;
  localparam int FREQ_W  = 32;
  localparam int WALL_W  = 63;
  localparam int NS_W    = 30;
  localparam int STAT_W  = 2;
  localparam int CIDX_W  = 2;

  localparam logic [DATA_W-1:0] NS_PER_SEC = 64'd1000000000;

  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NO_FREQ   = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_BACKWARDS = 2'd2;

  localparam logic [CIDX_W-1:0] REG_FREQUENCY    = 2'd0;
  localparam logic [CIDX_W-1:0] REG_COUNTER_MAX  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_WRAP_SECONDS = 2'd2;
  localparam logic [CIDX_W-1:0] REG_RAW_MODE     = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WRAP_DIV,
    ST_WRAP_MUL,
    ST_SEC_START,
    ST_SEC_DIV,
    ST_NS_MUL,
    ST_NS_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[rtl/mcet_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The divisor must be nonzero.
module mcet_div #(
  parameter int W = mcet_pkg::DATA_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CntW = $clog2(W + 1);

  logic [W-1:0]    dvs;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [W:0]      shifted;
  logic [W+1:0]    trial;
  logic            borrow;

  assign shifted = {rem, quot[W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs};
  assign borrow  = trial[W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[W-2:0], ~borrow};
      rem  <= borrow ? shifted[W-1:0] : trial[W-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/mcet_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shift-and-add multiplier, one multiplier bit per cycle, keeping the low W bits.
module mcet_mul #(
  parameter int W = mcet_pkg::DATA_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] mcand,
  input  logic [W-1:0] mplier,
  output logic         done,
  output logic [W-1:0] prod
);

  localparam int CntW = $clog2(W + 1);

  logic [W-1:0]    a_sh;
  logic [W-1:0]    b_sh;
  logic [CntW-1:0] cnt;
  logic            busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= mcand;
      b_sh <= mplier;
      prod <= '0;
    end else if (busy) begin
      a_sh <= {a_sh[W-2:0], 1'b0};
      b_sh <= {1'b0, b_sh[W-1:1]};
      if (b_sh[0]) begin
        prod <= prod + a_sh;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/monotonic_counter_extend_timespec.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake           Payload
// in       to block   in_valid/in_stall   raw_counter, wall_seconds
// out      from block out_valid/out_stall seconds, nanoseconds, status
// cfg      to block   cfg_wen             cfg_index, cfg_data
//
// One item at a time: each beat passes through check, start, three bit-serial passes
// (tick divide, rem times 1e9, fraction divide) and a done state that loads the
// result; the next beat is taken once the block is back in idle. A wrap in extended
// mode adds a divide and a multiply. Zero frequency and backward wall time go from
// check straight to done. Reset is synchronous with no clearing pass; the output register
// lets the next beat in while a result waits under out_stall.
module monotonic_counter_extend_timespec (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mcet_pkg::DATA_W-1:0]       raw_counter,
  input  logic [mcet_pkg::WALL_W-1:0]       wall_seconds,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mcet_pkg::DATA_W-1:0]       seconds,
  output logic [mcet_pkg::NS_W-1:0]         nanoseconds,
  output logic [mcet_pkg::STAT_W-1:0]       status,
  input  logic                              cfg_wen,
  input  logic [mcet_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [mcet_pkg::DATA_W-1:0]       cfg_data
);

  localparam int W = mcet_pkg::DATA_W;

  mcet_pkg::state_t state, state_next;

  logic [mcet_pkg::FREQ_W-1:0] frequency;
  logic [W-1:0]                counter_max;
  logic [W-1:0]                wrap_seconds;
  logic                        raw_mode;

  logic [mcet_pkg::WALL_W-1:0] last_wall;
  logic [W-1:0]                last_count;
  logic [W-1:0]                count_base;

  logic [W-1:0]                raw_q;
  logic [mcet_pkg::WALL_W-1:0] wall_q;

  logic [W-1:0]                res_sec;
  logic [mcet_pkg::NS_W-1:0]   res_ns;
  logic [mcet_pkg::STAT_W-1:0] res_status;

  logic [mcet_pkg::WALL_W-1:0] prev_wall;
  logic [W-1:0]                prev_count;
  logic [W-1:0]                interval;
  logic [W-1:0]                freq_ext;
  logic                        backwards;
  logic                        wrapped;

  logic         div_start, div_done;
  logic [W-1:0] div_a, div_b, div_quot, div_rem;
  logic         mul_start, mul_done;
  logic [W-1:0] mul_a, mul_b, mul_prod;
  logic         in_take, out_load;

  assign in_stall  = (state != mcet_pkg::ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_load  = (state == mcet_pkg::ST_DONE) && (!out_valid || !out_stall);

  // The first extended sample stands in as its own predecessor.
  assign prev_wall  = (last_wall == '0) ? wall_q : last_wall;
  assign prev_count = (last_wall == '0) ? raw_q : last_count;
  assign backwards  = wall_q < prev_wall;
  assign wrapped    = prev_count > raw_q;
  assign interval   = (wrap_seconds == '0) ? W'(1) : wrap_seconds;
  assign freq_ext   = W'(frequency);

  mcet_div #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  mcet_mul #(.W(W)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mul_a),
    .mplier (mul_b),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcet_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_a      = '0;
    div_b      = freq_ext;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      mcet_pkg::ST_IDLE: begin
        if (in_take) begin
          state_next = mcet_pkg::ST_CHECK;
        end
      end
      mcet_pkg::ST_CHECK: begin
        if (frequency == '0) begin
          state_next = mcet_pkg::ST_DONE;
        end else if (raw_mode) begin
          state_next = mcet_pkg::ST_SEC_START;
        end else if (backwards) begin
          state_next = mcet_pkg::ST_DONE;
        end else if (wrapped) begin
          div_start  = 1'b1;
          div_a      = W'(wall_q - prev_wall);
          div_b      = interval;
          state_next = mcet_pkg::ST_WRAP_DIV;
        end else begin
          state_next = mcet_pkg::ST_SEC_START;
        end
      end
      mcet_pkg::ST_WRAP_DIV: begin
        if (div_done) begin
          // Fewer than one elapsed interval still counts as one period.
          mul_start  = 1'b1;
          mul_a      = counter_max + W'(1);
          mul_b      = (div_quot == '0) ? W'(1) : div_quot;
          state_next = mcet_pkg::ST_WRAP_MUL;
        end
      end
      mcet_pkg::ST_WRAP_MUL: begin
        if (mul_done) begin
          state_next = mcet_pkg::ST_SEC_START;
        end
      end
      mcet_pkg::ST_SEC_START: begin
        div_start  = 1'b1;
        div_a      = raw_mode ? raw_q : count_base + raw_q;
        state_next = mcet_pkg::ST_SEC_DIV;
      end
      mcet_pkg::ST_SEC_DIV: begin
        if (div_done) begin
          mul_start  = 1'b1;
          mul_a      = div_rem;
          mul_b      = mcet_pkg::NS_PER_SEC;
          state_next = mcet_pkg::ST_NS_MUL;
        end
      end
      mcet_pkg::ST_NS_MUL: begin
        if (mul_done) begin
          div_start  = 1'b1;
          div_a      = mul_prod;
          state_next = mcet_pkg::ST_NS_DIV;
        end
      end
      mcet_pkg::ST_NS_DIV: begin
        if (div_done) begin
          state_next = mcet_pkg::ST_DONE;
        end
      end
      mcet_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = mcet_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mcet_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frequency    <= '0;
      counter_max  <= '1;
      wrap_seconds <= W'(1);
      raw_mode     <= 1'b1;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        mcet_pkg::REG_FREQUENCY:    frequency    <= cfg_data[mcet_pkg::FREQ_W-1:0];
        mcet_pkg::REG_COUNTER_MAX:  counter_max  <= cfg_data;
        mcet_pkg::REG_WRAP_SECONDS: wrap_seconds <= cfg_data;
        mcet_pkg::REG_RAW_MODE:     raw_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_wall  <= '0;
      last_count <= '0;
      count_base <= '0;
    end else begin
      if (state == mcet_pkg::ST_CHECK && frequency != '0 && !raw_mode && !backwards) begin
        last_wall  <= wall_q;
        last_count <= raw_q;
      end
      if (state == mcet_pkg::ST_WRAP_MUL && mul_done) begin
        count_base <= count_base + mul_prod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      raw_q  <= raw_counter;
      wall_q <= wall_seconds;
    end
    if (state == mcet_pkg::ST_CHECK) begin
      res_sec <= '0;
      res_ns  <= '0;
      if (frequency == '0) begin
        res_status <= mcet_pkg::STATUS_NO_FREQ;
      end else if (!raw_mode && backwards) begin
        res_status <= mcet_pkg::STATUS_BACKWARDS;
      end else begin
        res_status <= mcet_pkg::STATUS_OK;
      end
    end
    if (state == mcet_pkg::ST_SEC_DIV && div_done) begin
      res_sec <= div_quot;
    end
    if (state == mcet_pkg::ST_NS_DIV && div_done) begin
      res_ns <= div_quot[mcet_pkg::NS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      seconds     <= res_sec;
      nanoseconds <= res_ns;
      status      <= res_status;
    end
  end

endmodule

`default_nettype wire

[verif/timespec_compare.sv]
`timescale 1ns / 1ps

// Watches the configuration port and both channels, keeps its own copy of the
// registers and of the wrap-extension state, and checks every output beat
// against the oldest predicted reading.
module timespec_compare (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [mcet_pkg::DATA_W-1:0] raw_counter,
  input  logic [mcet_pkg::WALL_W-1:0] wall_seconds,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [mcet_pkg::DATA_W-1:0] seconds,
  input  logic [mcet_pkg::NS_W-1:0]   nanoseconds,
  input  logic [mcet_pkg::STAT_W-1:0] status,
  input  logic                        cfg_wen,
  input  logic [mcet_pkg::CIDX_W-1:0] cfg_index,
  input  logic [mcet_pkg::DATA_W-1:0] cfg_data,
  output int                          mismatches,
  output int                          outstanding
);

  import mcet_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] secs;
    logic [NS_W-1:0]   nsec;
    logic [STAT_W-1:0] code;
  } timespec_t;

  logic [FREQ_W-1:0] freq_r;
  logic [DATA_W-1:0] cmax_r;
  logic [DATA_W-1:0] wrap_r;
  logic              raw_r;

  logic [WALL_W-1:0] last_wall_r;
  logic [DATA_W-1:0] last_count_r;
  logic [DATA_W-1:0] base_r;

  timespec_t pending_times[$];
  int        err_count;

  function automatic timespec_t ticks_to_timespec(logic [DATA_W-1:0] ticks,
                                                  logic [FREQ_W-1:0] freq);
    logic [DATA_W-1:0] divisor;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] frac;
    timespec_t         r;
    divisor = {{(DATA_W-FREQ_W){1'b0}}, freq};
    rem     = ticks % divisor;
    // The remainder is below 2^32, so rem * 1e9 stays within 64 bits.
    frac    = (rem * NS_PER_SEC) / divisor;
    r.secs  = ticks / divisor;
    r.nsec  = frac[NS_W-1:0];
    r.code  = STATUS_OK;
    return r;
  endfunction

  function automatic timespec_t predict_timespec(logic [DATA_W-1:0] raw,
                                                 logic [WALL_W-1:0] wall);
    logic [WALL_W-1:0] prev_wall;
    logic [DATA_W-1:0] prev_count;
    logic [DATA_W-1:0] elapsed;
    logic [DATA_W-1:0] span;
    logic [DATA_W-1:0] periods;
    timespec_t         r;
    r = '0;
    if (freq_r == '0) begin
      r.code = STATUS_NO_FREQ;
      return r;
    end
    if (raw_r)
      return ticks_to_timespec(raw, freq_r);
    prev_wall  = last_wall_r;
    prev_count = last_count_r;
    // A stored wall time of zero means no extended sample has been seen yet.
    if (prev_wall == '0) begin
      prev_wall  = wall;
      prev_count = raw;
    end
    if (wall < prev_wall) begin
      r.code = STATUS_BACKWARDS;
      return r;
    end
    elapsed = {1'b0, wall} - {1'b0, prev_wall};
    span    = (wrap_r == '0) ? 64'd1 : wrap_r;
    if (prev_count > raw) begin
      periods = 64'd1;
      if (elapsed > span)
        periods = elapsed / span;
      base_r = base_r + periods * (cmax_r + 64'd1);
    end
    last_wall_r  = wall;
    last_count_r = raw;
    return ticks_to_timespec(base_r + raw, freq_r);
  endfunction

  always @(posedge clk) begin
    timespec_t want;
    if (rst) begin
      freq_r       = '0;
      cmax_r       = '1;
      wrap_r       = 64'd1;
      raw_r        = 1'b1;
      last_wall_r  = '0;
      last_count_r = '0;
      base_r       = '0;
      err_count    = 0;
      pending_times.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_FREQUENCY:    freq_r = cfg_data[FREQ_W-1:0];
          REG_COUNTER_MAX:  cmax_r = cfg_data;
          REG_WRAP_SECONDS: wrap_r = cfg_data;
          REG_RAW_MODE:     raw_r  = cfg_data[0];
          default: ;
        endcase
      end
      // A result can never belong to a beat taken at the same edge, so the
      // output side is checked before the new prediction goes in.
      if (out_valid && !out_stall) begin
        if (pending_times.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result: seconds %0d ns %0d status %0d",
                   $time, seconds, nanoseconds, status);
        end else begin
          want = pending_times.pop_front();
          if (seconds !== want.secs) begin
            err_count++;
            $display("%0t: seconds expected %0d actual %0d", $time, want.secs, seconds);
          end
          if (nanoseconds !== want.nsec) begin
            err_count++;
            $display("%0t: nanoseconds expected %0d actual %0d",
                     $time, want.nsec, nanoseconds);
          end
          if (status !== want.code) begin
            err_count++;
            $display("%0t: status expected %0d actual %0d", $time, want.code, status);
          end
        end
      end
      if (in_valid && !in_stall)
        pending_times.push_back(predict_timespec(raw_counter, wall_seconds));
    end
    mismatches  <= err_count;
    outstanding <= pending_times.size();
  end

endmodule

[verif/monotonic_counter_extend_timespec_test.sv]
`timescale 1ns / 1ps

module monotonic_counter_extend_timespec_test;

  import mcet_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 2000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 144;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [DATA_W-1:0] raw_counter = '0;
  logic [WALL_W-1:0] wall_seconds = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] seconds;
  logic [NS_W-1:0]   nanoseconds;
  logic [STAT_W-1:0] status;
  logic              cfg_wen = 1'b0;
  logic [CIDX_W-1:0] cfg_index = REG_FREQUENCY;
  logic [DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int cycle_count = 0;

  // Shared shaping flags: steady turns idling off on both sides, squeeze asks
  // the receiver for one long hold-off while the sender keeps pushing.
  logic steady  = 1'b0;
  logic squeeze = 1'b0;

  logic [DATA_W-1:0] cur_raw;
  logic [WALL_W-1:0] cur_wall;
  logic [DATA_W-1:0] phase_cmax;

  always #5 clk = ~clk;

  monotonic_counter_extend_timespec DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .raw_counter  (raw_counter),
    .wall_seconds (wall_seconds),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .seconds      (seconds),
    .nanoseconds  (nanoseconds),
    .status       (status),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  timespec_compare compare_u (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .raw_counter  (raw_counter),
    .wall_seconds (wall_seconds),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .seconds      (seconds),
    .nanoseconds  (nanoseconds),
    .status       (status),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly no gap or a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Moves a counter forward by ticks, wrapping after cmax.
  function automatic logic [DATA_W-1:0] advance_count(logic [DATA_W-1:0] cnt,
                                                      logic [DATA_W-1:0] ticks,
                                                      logic [DATA_W-1:0] cmax);
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] s;
    if (cmax == '1) return cnt + ticks;
    if (cmax == '0) return '0;
    m = cmax + 64'd1;
    a = cnt % m;
    b = ticks % m;
    s = a + b;
    if (s < a || s >= m) s = s - m;
    return s;
  endfunction

  task automatic send_sample(logic [DATA_W-1:0] raw, logic [WALL_W-1:0] wall);
    int n;
    in_valid     <= 1'b1;
    raw_counter  <= raw;
    wall_seconds <= wall;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = (steady || squeeze) ? 0 : gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Writes all four registers once the block has drained.
  task automatic apply_settings(logic [FREQ_W-1:0] freq, logic [DATA_W-1:0] cmax,
                                logic [DATA_W-1:0] wrap, logic raw_mode);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_FREQUENCY;
    cfg_data  <= {{(DATA_W-FREQ_W){1'b0}}, freq};
    @(posedge clk);
    cfg_index <= REG_COUNTER_MAX;
    cfg_data  <= cmax;
    @(posedge clk);
    cfg_index <= REG_WRAP_SECONDS;
    cfg_data  <= wrap;
    @(posedge clk);
    cfg_index <= REG_RAW_MODE;
    cfg_data  <= {{(DATA_W-1){1'b0}}, raw_mode};
    @(posedge clk);
    cfg_wen   <= 1'b0;
    phase_cmax = cmax;
  endtask

  initial begin : receiver
    bit squeezed;
    int n;
    squeezed = 1'b0;
    forever begin
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (steady) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [FREQ_W-1:0] freq;
    logic [DATA_W-1:0] cmax;
    logic [DATA_W-1:0] wrap;
    logic [DATA_W-1:0] ticks;
    logic [DATA_W-1:0] raw;
    logic [WALL_W-1:0] wall;
    int                kind;

    phase_cmax = '1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers still at reset: zero frequency is unsupported.
    send_sample('1, '1);
    send_sample('0, '0);

    // Raw conversion at the edges of the tick and frequency ranges.
    apply_settings(32'd1000000000, '1, 64'd1, 1'b1);
    send_sample('0, 63'd3);
    send_sample('1, 63'd3);
    send_sample(64'd999999999, 63'd3);
    send_sample(64'd1000000000, 63'd3);
    apply_settings('1, '1, 64'd1, 1'b1);
    send_sample('1, '0);
    send_sample(64'hFFFF_FFFF_FFFF_FFFE, '1);
    apply_settings(32'd1, '1, 64'd1, 1'b1);
    send_sample('1, '0);

    // Extended mode: first sample, steady count, equal sample, short wrap,
    // wrap after several intervals, backward wall time, elapsed equal to the
    // interval.
    apply_settings(32'd1000, 64'd9999, 64'd10, 1'b0);
    send_sample(64'd100, 63'd5);
    send_sample(64'd200, 63'd6);
    send_sample(64'd200, 63'd6);
    send_sample(64'd50, 63'd8);
    send_sample(64'd10, 63'd48);
    send_sample(64'd20, 63'd47);
    send_sample(64'd5, 63'd58);
    // A wrap interval of zero counts as one second.
    apply_settings(32'd1000, 64'd9999, 64'd0, 1'b0);
    send_sample(64'd1, 63'd61);
    // With an all-ones maximum a wrap adds nothing to the base.
    apply_settings(32'd1000, '1, 64'd5, 1'b0);
    send_sample(64'd0, 63'd62);
    send_sample('1, '1);
    apply_settings(32'd0, '1, 64'd5, 1'b0);
    send_sample(64'd7, '1);

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 9))
        0:       freq = '0;
        1:       freq = 32'd1;
        2, 3:    freq = '1;
        4:       freq = 32'd1000000000;
        5, 6:    freq = $urandom_range(1, 1000);
        default: freq = $urandom();
      endcase
      if (freq == '0 && p == 0) freq = 32'd1000000000;
      case ($urandom_range(0, 5))
        0:       cmax = '1;
        1:       cmax = '0;
        2, 3:    cmax = DATA_W'($urandom_range(1, 65535));
        4:       cmax = {32'd0, $urandom()};
        default: cmax = rand64();
      endcase
      case ($urandom_range(0, 5))
        0:       wrap = '0;
        1:       wrap = 64'd1;
        2:       wrap = '1;
        3, 4:    wrap = DATA_W'($urandom_range(1, 20));
        default: wrap = rand64();
      endcase
      apply_settings(freq, cmax, wrap, $urandom_range(0, 3) == 0);
      if (p == 0) squeeze <= 1'b1;
      if (p == 3) steady <= 1'b1;
      cur_raw  = DATA_W'($urandom_range(0, 1000));
      cur_wall = WALL_W'($urandom_range(1, 100));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 0 && i == 30) squeeze <= 1'b0;
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
          // A plausible next reading: a little wall time and some ticks.
          if ($urandom_range(0, 9) == 0)
            cur_wall = cur_wall + WALL_W'($urandom_range(4, 200));
          else
            cur_wall = cur_wall + WALL_W'($urandom_range(0, 3));
          case ($urandom_range(0, 2))
            0:       ticks = DATA_W'($urandom_range(0, 5000));
            1:       ticks = rand64() >> $urandom_range(0, 63);
            default: ticks = phase_cmax - DATA_W'($urandom_range(0, 3));
          endcase
          cur_raw = advance_count(cur_raw, ticks, phase_cmax);
          raw  = cur_raw;
          wall = cur_wall;
        end else if (kind < 90) begin
          raw  = rand64();
          wall = ($urandom_range(0, 3) == 0) ? '0 : WALL_W'(rand64() >> 1);
          cur_raw  = raw;
          cur_wall = wall;
        end else if (kind < 96) begin
          raw  = rand64();
          wall = (cur_wall > WALL_W'(5)) ? cur_wall - WALL_W'($urandom_range(1, 5))
                                         : cur_wall;
        end else begin
          raw  = cur_raw;
          wall = cur_wall;
        end
        send_sample(raw, wall);
      end
      if (p == 3) steady <= 1'b0;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
